// ----- design/ihex_pkg.sv -----
// Shared types, constants and helpers for the Intel HEX record encoder.
package ihex_pkg;

   localparam int POS_W = 5;
   localparam logic [POS_W-1:0] HDR_BYTES = 5'd4;
   localparam logic [POS_W-1:0] ULA_CSUM_POS = 5'd6;
   localparam logic [POS_W-1:0] EOF_CSUM_POS = 5'd4;

   localparam logic [7:0] ULA_BYTE_COUNT = 8'h02;
   localparam logic [7:0] REC_TYPE_DATA = 8'h00;
   localparam logic [7:0] REC_TYPE_EOF = 8'h01;
   localparam logic [7:0] REC_TYPE_ULA = 8'h04;

   localparam logic ACTION_APPEND = 1'b0;
   localparam logic ACTION_CLOSE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_ULA,
      ST_DATA,
      ST_EOF
   } enc_state_type;

   typedef struct packed {
      logic       action;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [6:0] hex_high_char;
      logic [6:0] hex_low_char;
      logic       line_start;
      logic       line_end;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] byte_val;
      logic       line_start;
      logic       line_end;
      logic       last;
   } emit_type;

   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] res;
      if (nib < 4'd10) begin
         res = 7'h30 + {3'b000, nib};
      end else begin
         res = 7'h37 + {3'b000, nib};
      end
      return res;
   endfunction

endpackage

// ----- design/ihex_char_out.sv -----
// Output register stage that turns record bytes into ASCII hex characters.
module ihex_char_out
   import ihex_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     load,
   input  emit_type emit,
   output logic     load_ready,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   logic    valid_ff;
   rsp_type data_ff;

   assign load_ready = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load && load_ready) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load && load_ready) begin
         data_ff.hex_high_char <= hex_char(emit.byte_val[7:4]);
         data_ff.hex_low_char <= hex_char(emit.byte_val[3:0]);
         data_ff.line_start <= emit.line_start;
         data_ff.line_end <= emit.line_end;
         data_ff.last <= emit.last;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data = data_ff;

endmodule

// ----- design/intel_hex_record_encoder_core.sv -----
// Top level of the Intel HEX record encoder with a record buffer memory and byte sequencer.
//
// Each request appends one data byte or closes the stream. An append that does not complete a
// record is accepted without a stall and produces nothing. An append that completes a record of
// RECORD_BYTES bytes keeps the request side stalled while an extended linear address record
// (when one is needed) and the data record are emitted; a close adds the flush of a partial
// record (if any) and the end-of-file record. The sequencer emits one record byte per cycle
// while the output stage is not stalled, reading each stored data byte from the record buffer
// memory into a read register ahead of its turn, so the byte rate of the output stage sets the
// throughput. The base address register may be written only while no request is in progress.
module intel_hex_record_encoder_core
   import ihex_pkg::*;
#(
   parameter int RECORD_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   localparam int CNT_W = $clog2(RECORD_BYTES + 1);
   localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

   enc_state_type    state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       sum_ff, sum_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]      rec_pos_ff, rec_pos_in;
   logic [31:0]      addr_ff, addr_in;
   logic [15:0]      upper_ff, upper_in;
   logic             upper_sent_ff, upper_sent_in;
   logic             close_ff, close_in;
   logic [31:0]      base_ff;

   logic [7:0]       rec_mem [RECORD_BYTES];
   logic [7:0]       rd_data_ff;
   logic             rd_en;
   logic [IDX_W-1:0] rd_idx;
   logic [POS_W-1:0] pos_next;
   logic [POS_W-1:0] data_end;

   logic             req_fire;
   logic             wr_en;
   logic             emit_valid;
   logic             out_ready;
   logic             adv;
   emit_type         emit;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire = req_valid && !req_stall;
   assign wr_en = req_fire && (req_data.action == ACTION_APPEND);
   assign emit_valid = (state_ff == ST_ULA) || (state_ff == ST_DATA) || (state_ff == ST_EOF);
   assign adv = emit_valid && out_ready;
   assign pos_next = pos_ff + 5'd1;
   assign data_end = HDR_BYTES + POS_W'(cnt_ff);
   assign rd_en = adv && (state_ff == ST_DATA) && (pos_next >= HDR_BYTES)
                  && (pos_next < data_end);
   assign rd_idx = IDX_W'(pos_next - HDR_BYTES);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rec_mem[fill_ff[IDX_W-1:0]] <= req_data.data_byte;
      end
      if (rd_en) begin
         rd_data_ff <= rec_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         base_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff <= '0;
         sum_ff <= '0;
         fill_ff <= '0;
         cnt_ff <= '0;
         rec_pos_ff <= '0;
         addr_ff <= '0;
         upper_ff <= '0;
         upper_sent_ff <= 1'b0;
         close_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         sum_ff <= sum_in;
         fill_ff <= fill_in;
         cnt_ff <= cnt_in;
         rec_pos_ff <= rec_pos_in;
         addr_ff <= addr_in;
         upper_ff <= upper_in;
         upper_sent_ff <= upper_sent_in;
         close_ff <= close_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      sum_in = sum_ff;
      fill_in = fill_ff;
      cnt_in = cnt_ff;
      rec_pos_in = rec_pos_ff;
      addr_in = addr_ff;
      upper_in = upper_ff;
      upper_sent_in = upper_sent_ff;
      close_in = close_ff;
      emit = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               addr_in = base_ff + rec_pos_ff;
               pos_in = '0;
               if (req_data.action == ACTION_APPEND) begin
                  close_in = 1'b0;
                  if (fill_ff == CNT_W'(RECORD_BYTES - 1)) begin
                     cnt_in = CNT_W'(RECORD_BYTES);
                     fill_in = '0;
                     rec_pos_in = rec_pos_ff + 32'(RECORD_BYTES);
                     state_in = ST_SETUP;
                  end else begin
                     fill_in = fill_ff + CNT_W'(1);
                  end
               end else begin
                  close_in = 1'b1;
                  cnt_in = fill_ff;
                  fill_in = '0;
                  rec_pos_in = '0;
                  state_in = (fill_ff == '0) ? ST_EOF : ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            if (!upper_sent_ff || (addr_ff[31:16] != upper_ff)) begin
               upper_in = addr_ff[31:16];
               upper_sent_in = 1'b1;
               state_in = ST_ULA;
            end else begin
               state_in = ST_DATA;
            end
         end
         ST_ULA: begin
            emit.line_start = (pos_ff == '0);
            emit.line_end = (pos_ff == ULA_CSUM_POS);
            case (pos_ff)
               5'd0: emit.byte_val = ULA_BYTE_COUNT;
               5'd1: emit.byte_val = 8'h00;
               5'd2: emit.byte_val = 8'h00;
               5'd3: emit.byte_val = REC_TYPE_ULA;
               5'd4: emit.byte_val = upper_ff[15:8];
               5'd5: emit.byte_val = upper_ff[7:0];
               default: emit.byte_val = 8'h00 - sum_ff;
            endcase
            if (adv) begin
               if (pos_ff == ULA_CSUM_POS) begin
                  pos_in = '0;
                  state_in = ST_DATA;
               end else begin
                  pos_in = pos_next;
               end
            end
         end
         ST_DATA: begin
            emit.line_start = (pos_ff == '0);
            emit.line_end = (pos_ff == data_end);
            emit.last = (pos_ff == data_end) && !close_ff;
            if (pos_ff == '0) begin
               emit.byte_val = 8'(cnt_ff);
            end else if (pos_ff == 5'd1) begin
               emit.byte_val = addr_ff[15:8];
            end else if (pos_ff == 5'd2) begin
               emit.byte_val = addr_ff[7:0];
            end else if (pos_ff == 5'd3) begin
               emit.byte_val = REC_TYPE_DATA;
            end else if (pos_ff == data_end) begin
               emit.byte_val = 8'h00 - sum_ff;
            end else begin
               emit.byte_val = rd_data_ff;
            end
            if (adv) begin
               if (pos_ff == data_end) begin
                  pos_in = '0;
                  state_in = close_ff ? ST_EOF : ST_IDLE;
               end else begin
                  pos_in = pos_next;
               end
            end
         end
         ST_EOF: begin
            emit.line_start = (pos_ff == '0);
            emit.line_end = (pos_ff == EOF_CSUM_POS);
            emit.last = (pos_ff == EOF_CSUM_POS);
            if (pos_ff == 5'd3) begin
               emit.byte_val = REC_TYPE_EOF;
            end else if (pos_ff == EOF_CSUM_POS) begin
               emit.byte_val = 8'h00 - sum_ff;
            end else begin
               emit.byte_val = 8'h00;
            end
            if (adv) begin
               if (pos_ff == EOF_CSUM_POS) begin
                  pos_in = '0;
                  upper_in = '0;
                  upper_sent_in = 1'b0;
                  close_in = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  pos_in = pos_next;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (adv) begin
         sum_in = (pos_ff == '0) ? emit.byte_val : sum_ff + emit.byte_val;
      end
   end

   ihex_char_out u_char_out (
      .clock      (clock),
      .reset      (reset),
      .load       (emit_valid),
      .emit       (emit),
      .load_ready (out_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   a_append_partial: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_data.action == ACTION_APPEND)
         && (fill_ff != CNT_W'(RECORD_BYTES - 1)))
      |=> (fill_ff == $past(fill_ff) + CNT_W'(1)) && (state_ff == ST_IDLE))
      else $error("partial append did not just store the byte");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> rsp_data.line_end)
      else $error("final result is not a checksum byte");

   a_data_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DATA) |-> (pos_ff <= data_end))
      else $error("data record position ran past the checksum");

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EOF) && adv && (pos_ff == EOF_CSUM_POS)
      |=> !upper_sent_ff && (state_ff == ST_IDLE) && (fill_ff == '0) && (rec_pos_ff == '0))
      else $error("close did not clear the stream state");

endmodule
